// ===== rtl/core/smfb_pkg.sv =====
`default_nettype none

package smfb_pkg;

   // table size default
   localparam int MAX_SERVOS_DEF = 8;

   // frame constants
   localparam logic [7:0]  HDR_BYTE    = 8'h55;
   localparam logic [7:0]  CMD_MOVE    = 8'h03;
   localparam logic [7:0]  LEN_BASE    = 8'h05;
   localparam logic [15:0] ANGLE_RESET = 16'd1500;
   localparam logic [3:0]  COUNT_RESET = 4'd6;

   // header byte position of the time high byte (last header byte)
   localparam logic [2:0]  HDR_LAST    = 3'd6;

   typedef enum logic [1:0] {
      OP_ANGLE = 2'd0,
      OP_ID    = 2'd1,
      OP_SEND  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HEAD,
      ST_BODY
   } state_type;

   typedef enum logic [1:0] {
      PH_ID,
      PH_ALO,
      PH_AHI
   } phase_type;

endpackage

`default_nettype wire

// ===== rtl/core/smfb_ram.sv =====
`default_nettype none

module smfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/servo_move_frame_builder_top.sv =====
// Channel  Dir  Transfer when             Payload
// req      in   req_tvalid & req_tready   tuser: op; tdata: slot, servo_id, angle, move_time
// rsp      out  rsp_tvalid & rsp_tready   tdata: frame byte; tlast: final byte of frame
// csr      in   csr_we                    csr_wdata: servo_count
//
// Load items are taken whenever req_tready is high; req_tready stays high while no frame is being built.
// A send is accepted, then 7 + 3*n frame bytes follow at one byte per cycle while rsp_tready
// is high (n = servo_count, saturated to MAX_SERVOS): 25 bytes for six servos. Bytes come
// from the byte sequencer through the single output register.
// Reset (synchronous, active high) sets all angles to 1500 via per-slot valid bits
// and servo_count to 6; no clearing pass is needed. ID entries hold garbage until written.
// Backpressure on rsp freezes the sequencer; the table read address holds, so the
// registered RAM data stays valid across stalls.
`default_nettype none

module servo_move_frame_builder_top import smfb_pkg::*; #(
   parameter int MAX_SERVOS = MAX_SERVOS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // [2:0] slot, [10:3] servo_id,
                                        // [26:11] angle_value, [42:27] move_time
   input  wire logic [1:0]  req_tuser,  // [1:0] op
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // [7:0] frame_byte
   output logic             rsp_tlast,  // last_byte
   // servo_count register
   input  wire logic        csr_we,
   input  wire logic [3:0]  csr_wdata
);

   localparam int AW = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;

   // request fields
   logic [2:0]  req_slot;
   logic [7:0]  req_id;
   logic [15:0] req_angle;
   logic [15:0] req_time;

   assign req_slot  = req_tdata[2:0];
   assign req_id    = req_tdata[10:3];
   assign req_angle = req_tdata[26:11];
   assign req_time  = req_tdata[42:27];

   // state
   state_type        state_ff, state_in;
   logic [2:0]       hdr_ff, hdr_in;
   phase_type        phase_ff, phase_in;
   logic [AW-1:0]    slot_ff, slot_in;
   logic             last_slot_ff, last_slot_in;
   logic [15:0]      time_ff, time_in;
   logic [15:0]      hold_ff, hold_in;
   logic [3:0]       count_ff;
   logic [MAX_SERVOS-1:0] angle_vld_ff;
   logic             rd_vld_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             req_xfer;
   logic             send_xfer;
   logic             slot_ok;
   logic             wr_angle;
   logic             wr_id;
   logic             out_load;
   logic [7:0]       n_cnt;
   logic [7:0]       len_byte;
   logic             slot_last;
   logic [15:0]      rd_angle;
   logic [15:0]      rd_angle_eff;
   logic [7:0]       rd_id;
   logic [7:0]       hdr_byte;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign send_xfer  = req_xfer && (req_tuser == OP_SEND);
   assign slot_ok    = (8'(req_slot) < 8'(MAX_SERVOS));
   assign wr_angle   = req_xfer && (req_tuser == OP_ANGLE) && slot_ok;
   assign wr_id      = req_xfer && (req_tuser == OP_ID) && slot_ok;

   // output register takes a new byte when empty or being drained
   assign out_load = !rsp_valid_ff || rsp_tready;

   // effective count, saturated to table size; length = 5 + 3n
   assign n_cnt     = ({4'b0, count_ff} > 8'(MAX_SERVOS)) ? 8'(MAX_SERVOS) : {4'b0, count_ff};
   assign len_byte  = LEN_BASE + n_cnt + {n_cnt[6:0], 1'b0};
   assign slot_last = (8'(slot_ff) == (n_cnt - 8'd1));

   // unwritten angle entries read as the reset value
   assign rd_angle_eff = rd_vld_ff ? rd_angle : ANGLE_RESET;

   // tables: read address follows the slot pointer
   smfb_ram #(
      .WIDTH (16),
      .DEPTH (MAX_SERVOS)
   ) u_angle_ram (
      .clock   (clock),
      .wr_en   (wr_angle),
      .wr_addr (AW'(req_slot)),
      .wr_data (req_angle),
      .rd_addr (slot_ff),
      .rd_data (rd_angle)
   );

   smfb_ram #(
      .WIDTH (8),
      .DEPTH (MAX_SERVOS)
   ) u_id_ram (
      .clock   (clock),
      .wr_en   (wr_id),
      .wr_addr (AW'(req_slot)),
      .wr_data (req_id),
      .rd_addr (slot_ff),
      .rd_data (rd_id)
   );

   // header byte select
   always_comb begin
      case (hdr_ff)
         3'd0:    hdr_byte = HDR_BYTE;
         3'd1:    hdr_byte = HDR_BYTE;
         3'd2:    hdr_byte = len_byte;
         3'd3:    hdr_byte = CMD_MOVE;
         3'd4:    hdr_byte = n_cnt;
         3'd5:    hdr_byte = time_ff[7:0];
         default: hdr_byte = time_ff[15:8];
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (send_xfer) state_in = ST_HEAD;
         end
         ST_HEAD: begin
            if (out_load && (hdr_ff == HDR_LAST)) begin
               state_in = (n_cnt == 8'd0) ? ST_IDLE : ST_BODY;
            end
         end
         ST_BODY: begin
            if (out_load && (phase_ff == PH_AHI) && last_slot_ff) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer datapath and output register
   always_comb begin
      hdr_in       = hdr_ff;
      phase_in     = phase_ff;
      slot_in      = slot_ff;
      last_slot_in = last_slot_ff;
      time_in      = time_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (send_xfer) begin
               time_in  = req_time;
               hdr_in   = 3'd0;
               phase_in = PH_ID;
               slot_in  = '0;
            end
         end
         ST_HEAD: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hdr_byte;
               rsp_last_in  = (hdr_ff == HDR_LAST) && (n_cnt == 8'd0);
               hdr_in       = hdr_ff + 3'd1;
            end
         end
         ST_BODY: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               case (phase_ff)
                  PH_ID: begin
                     // RAM data is for the current slot; advance the pointer now so
                     // the next slot's data is ready when its ID byte is due
                     rsp_data_in  = rd_id;
                     rsp_last_in  = 1'b0;
                     hold_in      = rd_angle_eff;
                     last_slot_in = slot_last;
                     if (!slot_last) slot_in = slot_ff + AW'(1);
                     phase_in     = PH_ALO;
                  end
                  PH_ALO: begin
                     rsp_data_in = hold_ff[7:0];
                     rsp_last_in = 1'b0;
                     phase_in    = PH_AHI;
                  end
                  default: begin
                     rsp_data_in = hold_ff[15:8];
                     rsp_last_in = last_slot_ff;
                     phase_in    = PH_ID;
                  end
               endcase
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= COUNT_RESET;
         angle_vld_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) count_ff <= csr_wdata;
         if (wr_angle) angle_vld_ff[AW'(req_slot)] <= 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hdr_ff       <= hdr_in;
      phase_ff     <= phase_in;
      slot_ff      <= slot_in;
      last_slot_ff <= last_slot_in;
      time_ff      <= time_in;
      hold_ff      <= hold_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rd_vld_ff    <= angle_vld_ff[slot_ff];  // aligned with the RAM read
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/smfb_checker.sv =====
`default_nettype none

module smfb_checker import smfb_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast
);

   // nothing on the response side right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a send stops intake while its frame is built
   a_send_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_SEND) |=> !req_tready)
      else $error("request taken during frame build");

   // loads never produce a response byte
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != OP_SEND) && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response byte after a load");

   // a stalled byte holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

endmodule

bind servo_move_frame_builder_top smfb_checker u_smfb_checker (.*);

`default_nettype wire
